FILE: src/wtcs_pkg.sv
// Shared types and constants for the weighted trilinear colour sampler.
// Used by wtcs_map, wtcs_blend and the top module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wtcs_pkg;

    localparam int MAX_DIM_DEF    = 32;
    localparam int COLOR_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd6;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [32:0] HALF_Q16 = 33'd32768;

    typedef enum logic [3:0] {
        C_IDLE, C_MAP, C_RDA, C_RDB, C_RDW, C_BXW,
        C_BYS, C_BYW, C_BZS, C_BZW, C_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        M_IDLE, M_DIFF, M_MUL, M_CHK
    } map_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_KMUL, B_TOT, B_PMUL, B_SUM, B_DIV, B_DONE
    } blend_state_t;

    typedef struct packed {
        logic done;
        logic outside;
    } map_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } blend_stat_t;

endpackage

`default_nettype wire

FILE: src/wtcs_grid_mem.sv
// Grid cell store: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module wtcs_grid_mem #(
    parameter int AW = 15,
    parameter int DW = 49
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/wtcs_map.sv
// Point to cell mapper: one axis at a time through a shared 32x32 multiplier.
// Depends on wtcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtcs_map #(
    parameter int MAX_DIM = wtcs_pkg::MAX_DIM_DEF,
    localparam int IW = $clog2(MAX_DIM)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         point_x,
    input  logic [31:0]         point_y,
    input  logic [31:0]         point_z,
    input  logic [31:0]         origin_x,
    input  logic [31:0]         origin_y,
    input  logic [31:0]         origin_z,
    input  logic [31:0]         inv_cell_size,
    input  logic [5:0]          size_x,
    input  logic [5:0]          size_y,
    input  logic [5:0]          size_z,
    output wtcs_pkg::map_stat_t stat,
    output logic [IW-1:0]       idx_x,
    output logic [IW-1:0]       idx_y,
    output logic [IW-1:0]       idx_z,
    output logic [15:0]         frac_x,
    output logic [15:0]         frac_y,
    output logic [15:0]         frac_z
);

    wtcs_pkg::map_state_t state_reg, state_next;
    logic [1:0]    axis_reg;
    logic [32:0]   diff_reg;
    logic [63:0]   prod_reg;
    logic          outside_reg;
    logic [IW-1:0] idx_reg [3];
    logic [15:0]   frac_reg [3];

    logic [31:0] pt_sel, org_sel;
    logic [5:0]  size_sel;
    logic [32:0] size_ext, cap, cell_p1;
    logic        bad, diff_en, mul_en, chk_en, done;

    always_comb begin
        case (axis_reg)
            2'd0: begin
                pt_sel = point_x; org_sel = origin_x; size_sel = size_x;
            end
            2'd1: begin
                pt_sel = point_y; org_sel = origin_y; size_sel = size_y;
            end
            default: begin
                pt_sel = point_z; org_sel = origin_z; size_sel = size_z;
            end
        endcase
    end

    // size above the grid limit is clamped
    assign size_ext = 33'(size_sel);
    assign cap      = (size_ext > 33'(MAX_DIM)) ? 33'(MAX_DIM) : size_ext;
    assign cell_p1  = {1'b0, prod_reg[63:32]} + 33'd1;
    assign bad      = diff_reg[32] || (cell_p1 >= cap);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wtcs_pkg::M_IDLE: if (start) state_next = wtcs_pkg::M_DIFF;
            wtcs_pkg::M_DIFF: state_next = wtcs_pkg::M_MUL;
            wtcs_pkg::M_MUL:  state_next = wtcs_pkg::M_CHK;
            wtcs_pkg::M_CHK: begin
                state_next = (axis_reg == 2'd2) ? wtcs_pkg::M_IDLE : wtcs_pkg::M_DIFF;
            end
            default: state_next = wtcs_pkg::M_IDLE;
        endcase
    end

    always_comb begin
        diff_en = 1'b0;
        mul_en  = 1'b0;
        chk_en  = 1'b0;
        unique case (state_reg)
            wtcs_pkg::M_DIFF: diff_en = 1'b1;
            wtcs_pkg::M_MUL:  mul_en  = 1'b1;
            wtcs_pkg::M_CHK:  chk_en  = 1'b1;
            default: ;
        endcase
        done = chk_en && (axis_reg == 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wtcs_pkg::M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == wtcs_pkg::M_IDLE) begin
            axis_reg    <= 2'd0;
            outside_reg <= 1'b0;
        end
        if (diff_en) begin
            diff_reg <= {pt_sel[31], pt_sel} - {org_sel[31], org_sel};
        end
        if (mul_en) begin
            prod_reg <= 64'(diff_reg[31:0]) * 64'(inv_cell_size);
        end
        if (chk_en) begin
            idx_reg[axis_reg]  <= prod_reg[IW+31:32];
            frac_reg[axis_reg] <= prod_reg[31:16];
            outside_reg        <= outside_reg || bad;
            axis_reg           <= axis_reg + 2'd1;
        end
    end

    assign stat.done    = done;
    assign stat.outside = outside_reg || bad;
    assign idx_x  = idx_reg[0];
    assign idx_y  = idx_reg[1];
    assign idx_z  = idx_reg[2];
    assign frac_x = frac_reg[0];
    assign frac_y = frac_reg[1];
    assign frac_z = frac_reg[2];

endmodule

`default_nettype wire

FILE: src/wtcs_blend.sv
// Weighted blend of two colours: weight products, then a restoring divider
// giving one quotient bit a cycle, channel after channel. Depends on wtcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtcs_blend #(
    parameter int CB = wtcs_pkg::COLOR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2:0][CB-1:0]    c0,
    input  logic [16:0]           w0,
    input  logic [2:0][CB-1:0]    c1,
    input  logic [16:0]           w1,
    input  logic [15:0]           frac,
    output wtcs_pkg::blend_stat_t stat,
    output logic [2:0][CB-1:0]    c,
    output logic [16:0]           w
);

    localparam int PW = CB + 33;
    localparam int NW = PW + 1;
    localparam int CW = $clog2(CB);

    wtcs_pkg::blend_state_t state_reg, state_next;
    logic [2:0][CB-1:0] c0_reg, c1_reg, res_c_reg;
    logic [16:0]   w0_reg, w1_reg, res_w_reg;
    logic [15:0]   frac_reg;
    logic [32:0]   k0_reg, k1_reg, tot_reg;
    logic [PW-1:0] p0_reg, p1_reg;
    logic [NW-1:0] rem_reg, dvs_reg, rem_sub;
    logic [CB-1:0] q_reg, q_new;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    ch_reg;
    logic          q_bit, last_bit, last_ch, tot_zero;

    assign rem_sub  = rem_reg - dvs_reg;
    assign q_bit    = rem_reg >= dvs_reg;
    assign q_new    = {q_reg[CB-2:0], q_bit};
    assign last_bit = cnt_reg == CW'(CB - 1);
    assign last_ch  = ch_reg == 2'd2;
    assign tot_zero = tot_reg == '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wtcs_pkg::B_IDLE: if (start) state_next = wtcs_pkg::B_KMUL;
            wtcs_pkg::B_KMUL: state_next = wtcs_pkg::B_TOT;
            wtcs_pkg::B_TOT:  state_next = wtcs_pkg::B_PMUL;
            wtcs_pkg::B_PMUL: begin
                state_next = tot_zero ? wtcs_pkg::B_DONE : wtcs_pkg::B_SUM;
            end
            wtcs_pkg::B_SUM:  state_next = wtcs_pkg::B_DIV;
            wtcs_pkg::B_DIV: begin
                if (last_bit) begin
                    state_next = last_ch ? wtcs_pkg::B_DONE : wtcs_pkg::B_PMUL;
                end
            end
            wtcs_pkg::B_DONE: state_next = wtcs_pkg::B_IDLE;
            default: state_next = wtcs_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        stat.busy = state_reg != wtcs_pkg::B_IDLE;
        stat.done = state_reg == wtcs_pkg::B_DONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wtcs_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            wtcs_pkg::B_IDLE: begin
                if (start) begin
                    c0_reg   <= c0;
                    c1_reg   <= c1;
                    w0_reg   <= w0;
                    w1_reg   <= w1;
                    frac_reg <= frac;
                    ch_reg   <= 2'd0;
                end
            end
            wtcs_pkg::B_KMUL: begin
                k0_reg <= 33'(34'(w0_reg) * 34'(wtcs_pkg::ONE_Q16 - {1'b0, frac_reg}));
                k1_reg <= 33'(34'(w1_reg) * 34'(frac_reg));
            end
            wtcs_pkg::B_TOT: begin
                tot_reg <= k0_reg + k1_reg;
            end
            wtcs_pkg::B_PMUL: begin
                p0_reg <= PW'(k0_reg) * PW'(c0_reg[ch_reg]);
                p1_reg <= PW'(k1_reg) * PW'(c1_reg[ch_reg]);
                if (tot_zero) begin
                    res_c_reg <= '0;
                    res_w_reg <= '0;
                end else begin
                    res_w_reg <= 17'((tot_reg + wtcs_pkg::HALF_Q16) >> 16);
                end
            end
            wtcs_pkg::B_SUM: begin
                // rounding: add half the divisor before dividing
                rem_reg <= NW'(p0_reg) + NW'(p1_reg) + NW'(tot_reg >> 1);
                dvs_reg <= NW'(tot_reg) << (CB - 1);
                cnt_reg <= '0;
            end
            wtcs_pkg::B_DIV: begin
                if (q_bit) begin
                    rem_reg <= rem_sub;
                end
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + CW'(1);
                if (last_bit) begin
                    res_c_reg[ch_reg] <= q_new;
                    ch_reg            <= ch_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign c = res_c_reg;
    assign w = res_w_reg;

endmodule

`default_nettype wire

FILE: src/weighted_trilinear_color_sampler_top.sv
// Weighted trilinear colour sampler. A write word (tuser 0) stores one grid
// cell and returns a word of zeros. A sample word (tuser 1) maps the point
// onto the grid, three axes through one 32x32 multiplier; a point outside
// the grid returns white with the outside flag once the mapping is done.
// Inside, the eight corners are read from the single
// grid memory port, two reads per x pair, and seven blends run on one shared
// blend unit whose divider yields one quotient bit a cycle for each of the
// three channels. One word is processed at a time; a finished result waits
// in the output register while the next word is taken. A cell must be
// written before a sample reads it. Config writes are taken at any time but
// must only be issued while the block is idle. Depends on wtcs_pkg and the
// wtcs_map, wtcs_blend and wtcs_grid_mem modules.
`timescale 1ns / 1ps
`default_nettype none

module weighted_trilinear_color_sampler_top #(
    parameter int MAX_DIM    = wtcs_pkg::MAX_DIM_DEF,
    parameter int COLOR_BITS = wtcs_pkg::COLOR_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_i, cell_j, cell_k, cell_red, cell_green, cell_blue, cell_valid,
    // point_x, point_y, point_z
    input  logic [159:0] s_tdata,
    // opcode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_red, out_green, out_blue, out_weight, zero pad
    output logic [71:0]  m_tdata,
    // outside
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [wtcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 3 * IW;
    localparam int CB = COLOR_BITS;
    localparam int DW = 3 * CB + 1;

    wtcs_pkg::ctl_state_t state_reg, state_next;

    logic [31:0] origin_x_reg, origin_y_reg, origin_z_reg, inv_cell_reg;
    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [31:0] point_x_reg, point_y_reg, point_z_reg;

    logic [4:0]  cell_i, cell_j, cell_k;
    logic [15:0] cell_red, cell_green, cell_blue;
    logic        cell_valid, in_range;

    logic          mem_we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    wtcs_pkg::map_stat_t map_stat;
    logic          map_start;
    logic [IW-1:0] idx_x, idx_y, idx_z;
    logic [15:0]   frac_x, frac_y, frac_z;

    wtcs_pkg::blend_stat_t blend_stat;
    logic               blend_start;
    logic [2:0][CB-1:0] bl_c0, bl_c1, bl_res_c;
    logic [16:0]        bl_w0, bl_w1, bl_res_w;
    logic [15:0]        bl_a;

    logic [1:0]         pair_reg;
    logic [DW-1:0]      op0_reg;
    logic [2:0][CB-1:0] cx_c_reg [4];
    logic [16:0]        cx_w_reg [4];
    logic [2:0][CB-1:0] cy_c_reg [2];
    logic [16:0]        cy_w_reg [2];
    logic [IW-1:0]      rd_x, rd_y, rd_z;
    logic               rd_xoff;

    logic [2:0][15:0] res_c_reg;
    logic [16:0]      res_w_reg;
    logic             res_out_reg;
    logic             m_tvalid_reg;
    logic [71:0]      m_tdata_reg;
    logic [0:0]       m_tuser_reg;
    logic             out_free;

    assign cell_i     = s_tdata[4:0];
    assign cell_j     = s_tdata[9:5];
    assign cell_k     = s_tdata[14:10];
    assign cell_red   = s_tdata[30:15];
    assign cell_green = s_tdata[46:31];
    assign cell_blue  = s_tdata[62:47];
    assign cell_valid = s_tdata[63];

    assign in_range = (32'(cell_i) < 32'(MAX_DIM)) && (32'(cell_j) < 32'(MAX_DIM))
                   && (32'(cell_k) < 32'(MAX_DIM));
    assign waddr = {IW'(cell_i), IW'(cell_j), IW'(cell_k)};
    assign wdata = {cell_valid, CB'(cell_blue), CB'(cell_green), CB'(cell_red)};

    assign rd_x  = idx_x + IW'(rd_xoff);
    assign rd_y  = idx_y + IW'(pair_reg[0]);
    assign rd_z  = idx_z + IW'(pair_reg[1]);
    assign raddr = {rd_x, rd_y, rd_z};

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    wtcs_grid_mem #(.AW(AW), .DW(DW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    wtcs_map #(.MAX_DIM(MAX_DIM)) u_map (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (map_start),
        .point_x       (point_x_reg),
        .point_y       (point_y_reg),
        .point_z       (point_z_reg),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .inv_cell_size (inv_cell_reg),
        .size_x        (size_x_reg),
        .size_y        (size_y_reg),
        .size_z        (size_z_reg),
        .stat          (map_stat),
        .idx_x         (idx_x),
        .idx_y         (idx_y),
        .idx_z         (idx_z),
        .frac_x        (frac_x),
        .frac_y        (frac_y),
        .frac_z        (frac_z)
    );

    wtcs_blend #(.CB(CB)) u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blend_start),
        .c0      (bl_c0),
        .w0      (bl_w0),
        .c1      (bl_c1),
        .w1      (bl_w1),
        .frac    (bl_a),
        .stat    (blend_stat),
        .c       (bl_res_c),
        .w       (bl_res_w)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wtcs_pkg::C_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == wtcs_pkg::OP_WRITE) ?
                                 wtcs_pkg::C_OUT : wtcs_pkg::C_MAP;
                end
            end
            wtcs_pkg::C_MAP: begin
                if (map_stat.done) begin
                    state_next = map_stat.outside ? wtcs_pkg::C_OUT : wtcs_pkg::C_RDA;
                end
            end
            wtcs_pkg::C_RDA: state_next = wtcs_pkg::C_RDB;
            wtcs_pkg::C_RDB: state_next = wtcs_pkg::C_RDW;
            wtcs_pkg::C_RDW: state_next = wtcs_pkg::C_BXW;
            wtcs_pkg::C_BXW: begin
                if (blend_stat.done) begin
                    state_next = pair_reg[0] ? wtcs_pkg::C_BYS : wtcs_pkg::C_RDA;
                end
            end
            wtcs_pkg::C_BYS: state_next = wtcs_pkg::C_BYW;
            wtcs_pkg::C_BYW: begin
                if (blend_stat.done) begin
                    state_next = pair_reg[1] ? wtcs_pkg::C_BZS : wtcs_pkg::C_RDA;
                end
            end
            wtcs_pkg::C_BZS: state_next = wtcs_pkg::C_BZW;
            wtcs_pkg::C_BZW: if (blend_stat.done) state_next = wtcs_pkg::C_OUT;
            wtcs_pkg::C_OUT: if (out_free) state_next = wtcs_pkg::C_IDLE;
            default: state_next = wtcs_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        mem_we      = 1'b0;
        map_start   = 1'b0;
        blend_start = 1'b0;
        rd_xoff     = 1'b0;
        bl_c0 = op0_reg[DW-2:0];
        bl_w0 = op0_reg[DW-1] ? wtcs_pkg::ONE_Q16 : 17'd0;
        bl_c1 = rdata[DW-2:0];
        bl_w1 = rdata[DW-1] ? wtcs_pkg::ONE_Q16 : 17'd0;
        bl_a  = frac_x;
        unique case (state_reg)
            wtcs_pkg::C_IDLE: begin
                s_tready  = 1'b1;
                mem_we    = s_tvalid && (s_tuser[0] == wtcs_pkg::OP_WRITE) && in_range;
                map_start = s_tvalid && (s_tuser[0] == wtcs_pkg::OP_SAMPLE);
            end
            wtcs_pkg::C_RDB: rd_xoff = 1'b1;
            wtcs_pkg::C_RDW: blend_start = 1'b1;
            wtcs_pkg::C_BYS: begin
                blend_start = 1'b1;
                bl_c0 = pair_reg[1] ? cx_c_reg[2] : cx_c_reg[0];
                bl_w0 = pair_reg[1] ? cx_w_reg[2] : cx_w_reg[0];
                bl_c1 = pair_reg[1] ? cx_c_reg[3] : cx_c_reg[1];
                bl_w1 = pair_reg[1] ? cx_w_reg[3] : cx_w_reg[1];
                bl_a  = frac_y;
            end
            wtcs_pkg::C_BZS: begin
                blend_start = 1'b1;
                bl_c0 = cy_c_reg[0];
                bl_w0 = cy_w_reg[0];
                bl_c1 = cy_c_reg[1];
                bl_w1 = cy_w_reg[1];
                bl_a  = frac_z;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wtcs_pkg::C_IDLE;
            m_tvalid_reg <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_cell_reg <= 32'd65536;
            size_x_reg   <= 6'd32;
            size_y_reg   <= 6'd32;
            size_z_reg   <= 6'd32;
        end else begin
            state_reg <= state_next;
            if (state_reg == wtcs_pkg::C_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    wtcs_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    wtcs_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    wtcs_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    wtcs_pkg::REG_INV_CELL: inv_cell_reg <= cfg_data;
                    wtcs_pkg::REG_SIZE_X:   size_x_reg   <= cfg_data[5:0];
                    wtcs_pkg::REG_SIZE_Y:   size_y_reg   <= cfg_data[5:0];
                    wtcs_pkg::REG_SIZE_Z:   size_z_reg   <= cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            wtcs_pkg::C_IDLE: begin
                if (s_tvalid) begin
                    point_x_reg <= s_tdata[95:64];
                    point_y_reg <= s_tdata[127:96];
                    point_z_reg <= s_tdata[159:128];
                    res_c_reg   <= '0;
                    res_w_reg   <= '0;
                    res_out_reg <= 1'b0;
                end
            end
            wtcs_pkg::C_MAP: begin
                pair_reg <= 2'd0;
                if (map_stat.done && map_stat.outside) begin
                    res_c_reg   <= {3{16'({CB{1'b1}})}};
                    res_w_reg   <= '0;
                    res_out_reg <= 1'b1;
                end
            end
            wtcs_pkg::C_RDB: op0_reg <= rdata;
            wtcs_pkg::C_BXW: begin
                if (blend_stat.done) begin
                    cx_c_reg[pair_reg] <= bl_res_c;
                    cx_w_reg[pair_reg] <= bl_res_w;
                    if (!pair_reg[0]) pair_reg <= pair_reg + 2'd1;
                end
            end
            wtcs_pkg::C_BYW: begin
                if (blend_stat.done) begin
                    cy_c_reg[pair_reg[1]] <= bl_res_c;
                    cy_w_reg[pair_reg[1]] <= bl_res_w;
                    pair_reg <= 2'd2;
                end
            end
            wtcs_pkg::C_BZW: begin
                if (blend_stat.done) begin
                    res_c_reg[0] <= 16'(bl_res_c[0]);
                    res_c_reg[1] <= 16'(bl_res_c[1]);
                    res_c_reg[2] <= 16'(bl_res_c[2]);
                    res_w_reg    <= bl_res_w;
                    res_out_reg  <= 1'b0;
                end
            end
            wtcs_pkg::C_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {7'd0, res_w_reg, res_c_reg[2], res_c_reg[1],
                                    res_c_reg[0]};
                    m_tuser_reg <= res_out_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    a_blend_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_start |-> !blend_stat.busy)
        else $error("blend started while busy");
    a_map_done_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        map_stat.done |-> state_reg == wtcs_pkg::C_MAP)
        else $error("map finished outside map state");
    a_sample_enters_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == wtcs_pkg::OP_SAMPLE)
        |=> state_reg == wtcs_pkg::C_MAP)
        else $error("sample word did not start mapping");
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_stat.done |-> bl_res_w <= wtcs_pkg::ONE_Q16)
        else $error("blend weight above one");
`endif

endmodule

`default_nettype wire

FILE: tb/wtcs_scoreboard.sv
// Checker for the weighted trilinear colour sampler: watches the config, input and
// result channels, keeps its own copy of the grid and registers, and predicts each result.
// Depends on wtcs_pkg; instantiated by weighted_trilinear_color_sampler_top_test.
`timescale 1ns / 1ps

module wtcs_scoreboard (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [wtcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [16:0] weight;
        logic        outside;
    } colour_t;

    typedef struct packed {
        logic [47:0] rgb;
        logic [16:0] w;
    } mix_t;

    logic [47:0] cell_rgb [32768];
    logic        cell_occ [32768];
    logic [31:0] org_x, org_y, org_z, inv_cell;
    logic [5:0]  dim_x, dim_y, dim_z;
    colour_t     colours_due [$];
    int          nres;

    initial begin
        for (int n = 0; n < 32768; n++) begin
            cell_rgb[n] = '0;
            cell_occ[n] = 1'b0;
        end
        fail_count = 0;
        pending = 0;
    end

    function automatic mix_t mix(logic [47:0] c0, logic [16:0] w0, logic [47:0] c1,
                                 logic [16:0] w1, logic [15:0] a);
        logic [63:0] k0, k1, tot, num;
        mix_t res;
        k0 = 64'(w0) * (64'd65536 - 64'(a));
        k1 = 64'(w1) * 64'(a);
        tot = k0 + k1;
        res = '0;
        if (tot != 0) begin
            for (int ch = 0; ch < 3; ch++) begin
                num = k0 * 64'(c0[ch*16 +: 16]) + k1 * 64'(c1[ch*16 +: 16]);
                res.rgb[ch*16 +: 16] = 16'((num + tot / 2) / tot);
            end
            res.w = 17'((tot + 64'd32768) >> 16);
        end
        return res;
    endfunction

    function automatic logic locate(logic [31:0] pt, logic [31:0] org, logic [5:0] dim,
                                    output logic [4:0] idx, output logic [15:0] frac);
        logic signed [63:0] d;
        logic [63:0] u;
        logic [63:0] lim;
        idx = '0;
        frac = '0;
        d = 64'($signed(pt)) - 64'($signed(org));
        if (d < 0) return 1'b0;
        u = 64'(d) * 64'(inv_cell);
        lim = (dim > 6'd32) ? 64'd32 : 64'(dim);
        if ((u >> 32) + 64'd1 >= lim) return 1'b0;
        idx = 5'(u >> 32);
        frac = u[31:16];
        return 1'b1;
    endfunction

    function automatic int cell_addr(int i, int j, int k);
        return (i * 32 + j) * 32 + k;
    endfunction

    function automatic colour_t predict_colour(logic [159:0] d, logic op);
        colour_t res;
        logic [4:0]  ix, iy, iz;
        logic [15:0] fx, fy, fz;
        mix_t along_x [4];
        mix_t along_y [2];
        mix_t m;
        int a0, a1;
        res = '0;
        if (op == wtcs_pkg::OP_WRITE) begin
            a0 = cell_addr(d[4:0], d[9:5], d[14:10]);
            cell_rgb[a0] = d[62:15];
            cell_occ[a0] = d[63];
            return res;
        end
        if (!locate(d[95:64], org_x, dim_x, ix, fx) ||
            !locate(d[127:96], org_y, dim_y, iy, fy) ||
            !locate(d[159:128], org_z, dim_z, iz, fz)) begin
            res.red = 16'hFFFF;
            res.green = 16'hFFFF;
            res.blue = 16'hFFFF;
            res.outside = 1'b1;
            return res;
        end
        for (int n = 0; n < 4; n++) begin
            a0 = cell_addr(ix, iy + (n & 1), iz + (n >> 1));
            a1 = cell_addr(ix + 1, iy + (n & 1), iz + (n >> 1));
            along_x[n] = mix(cell_rgb[a0], cell_occ[a0] ? wtcs_pkg::ONE_Q16 : 17'd0,
                             cell_rgb[a1], cell_occ[a1] ? wtcs_pkg::ONE_Q16 : 17'd0, fx);
        end
        along_y[0] = mix(along_x[0].rgb, along_x[0].w, along_x[1].rgb, along_x[1].w, fy);
        along_y[1] = mix(along_x[2].rgb, along_x[2].w, along_x[3].rgb, along_x[3].w, fy);
        m = mix(along_y[0].rgb, along_y[0].w, along_y[1].rgb, along_y[1].w, fz);
        res.red = m.rgb[15:0];
        res.green = m.rgb[31:16];
        res.blue = m.rgb[47:32];
        res.weight = m.w;
        return res;
    endfunction

    task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: result %0d %s mismatch: expected %h actual %h",
                     $time, nres, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Inputs move only at rising edges, so the values at the falling edge are the
    // ones the next rising edge will take.
    always @(negedge aclk) begin
        colour_t exp_c;
        if (!aresetn) begin
            org_x = '0;
            org_y = '0;
            org_z = '0;
            inv_cell = 32'd65536;
            dim_x = 6'd32;
            dim_y = 6'd32;
            dim_z = 6'd32;
            colours_due.delete();
            nres = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wtcs_pkg::REG_ORIGIN_X: org_x = cfg_data;
                    wtcs_pkg::REG_ORIGIN_Y: org_y = cfg_data;
                    wtcs_pkg::REG_ORIGIN_Z: org_z = cfg_data;
                    wtcs_pkg::REG_INV_CELL: inv_cell = cfg_data;
                    wtcs_pkg::REG_SIZE_X:   dim_x = cfg_data[5:0];
                    wtcs_pkg::REG_SIZE_Y:   dim_y = cfg_data[5:0];
                    wtcs_pkg::REG_SIZE_Z:   dim_z = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (colours_due.size() == 0) begin
                    $display("%0t: unexpected result word: expected none actual %h/%h",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    exp_c = colours_due.pop_front();
                    check_field("red", 17'(exp_c.red), 17'(m_tdata[15:0]));
                    check_field("green", 17'(exp_c.green), 17'(m_tdata[31:16]));
                    check_field("blue", 17'(exp_c.blue), 17'(m_tdata[47:32]));
                    check_field("weight", exp_c.weight, m_tdata[64:48]);
                    check_field("outside", 17'(exp_c.outside), 17'(m_tuser[0]));
                end
                nres++;
            end
            if (s_tvalid && s_tready)
                colours_due.push_back(predict_colour(s_tdata, s_tuser[0]));
        end
        pending = colours_due.size();
    end

endmodule

FILE: tb/weighted_trilinear_color_sampler_top_test.sv
// Stimulus and verdict for the weighted trilinear colour sampler: several register
// settings, cell writes and sample points whose corners are always written first.
// Depends on wtcs_pkg, weighted_trilinear_color_sampler_top and wtcs_scoreboard.
`timescale 1ns / 1ps

module weighted_trilinear_color_sampler_top_test;

    localparam longint CYCLE_LIMIT = 4000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [wtcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending;

    logic [31:0]  org [3];
    logic [31:0]  inv_cell;
    logic [5:0]   dim [3];
    bit           written [32768];
    int           send_idle, recv_idle;
    longint       cycles = 0;
    int           words_sent = 0, samples_sent = 0, settings_run = 0;

    weighted_trilinear_color_sampler_top dut (.*);

    wtcs_scoreboard checker_i (.*);

    initial forever #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("weighted_trilinear_color_sampler_top_test: FAIL");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [159:0] d);
        logic rdy;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        words_sent++;
        if (op == wtcs_pkg::OP_SAMPLE) samples_sent++;
        if (words_sent == 470) begin
            send_idle = 62;
            recv_idle = 32;
        end else if (words_sent == 940) begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic write_cell(int i, int j, int k, logic [47:0] rgb, logic occ);
        written[(i * 32 + j) * 32 + k] = 1'b1;
        send_word(wtcs_pkg::OP_WRITE, {96'(0), occ, rgb, 5'(k), 5'(j), 5'(i)});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_reg(logic [wtcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
        end while (!rdy);
        case (idx)
            wtcs_pkg::REG_ORIGIN_X: org[0] = v;
            wtcs_pkg::REG_ORIGIN_Y: org[1] = v;
            wtcs_pkg::REG_ORIGIN_Z: org[2] = v;
            wtcs_pkg::REG_INV_CELL: inv_cell = v;
            wtcs_pkg::REG_SIZE_X:   dim[0] = v[5:0];
            wtcs_pkg::REG_SIZE_Y:   dim[1] = v[5:0];
            wtcs_pkg::REG_SIZE_Z:   dim[2] = v[5:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] inv, int sx, int sy, int sz);
        drain();
        set_reg(wtcs_pkg::REG_ORIGIN_X, ox);
        set_reg(wtcs_pkg::REG_ORIGIN_Y, oy);
        set_reg(wtcs_pkg::REG_ORIGIN_Z, oz);
        set_reg(wtcs_pkg::REG_INV_CELL, inv);
        set_reg(wtcs_pkg::REG_SIZE_X, 32'(sx));
        set_reg(wtcs_pkg::REG_SIZE_Y, 32'(sy));
        set_reg(wtcs_pkg::REG_SIZE_Z, 32'(sz));
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Lower cell index on one axis, or -1 when the point is off the usable grid.
    function automatic int axis_cell(logic [31:0] pt, int ax);
        logic signed [63:0] d;
        logic [63:0] u;
        int lim;
        d = 64'($signed(pt)) - 64'($signed(org[ax]));
        if (d < 0) return -1;
        u = 64'(d) * 64'(inv_cell);
        lim = (dim[ax] > 32) ? 32 : int'(dim[ax]);
        if ((u >> 32) + 1 >= 64'(lim)) return -1;
        return int'(u >> 32);
    endfunction

    function automatic logic [31:0] pick_coord(int ax);
        int r;
        logic [63:0] span;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom;
        if (r < 14) return org[ax] - 32'($urandom_range(1, 70000));
        span = (inv_cell == 0) ? 64'h7FFF_FFFF :
               ((64'(dim[ax] > 32 ? 32 : dim[ax]) + 64'd1) << 32) / 64'(inv_cell);
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        return org[ax] + 32'({$urandom, $urandom} % (span + 1));
    endfunction

    function automatic logic [47:0] pick_rgb();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
    endfunction

    // Writes any corner not yet written, then sends the sample.
    task automatic sample_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int ci, cj, ck;
        ci = axis_cell(px, 0);
        cj = axis_cell(py, 1);
        ck = axis_cell(pz, 2);
        if (ci >= 0 && cj >= 0 && ck >= 0)
            for (int n = 0; n < 8; n++)
                if (!written[((ci + n[0]) * 32 + cj + n[1]) * 32 + ck + n[2]])
                    write_cell(ci + n[0], cj + n[1], ck + n[2], pick_rgb(),
                               $urandom_range(0, 3) != 0);
        send_word(wtcs_pkg::OP_SAMPLE, {pz, py, px, 64'($urandom)});
    endtask

    // Sends about n words, corner writes included.
    task automatic random_words(int n);
        int first;
        first = words_sent;
        while (words_sent - first < n) begin
            if ($urandom_range(0, 99) < 30)
                send_word(wtcs_pkg::OP_WRITE,
                          {$urandom, $urandom, $urandom, $urandom, $urandom});
            else
                sample_point(pick_coord(0), pick_coord(1), pick_coord(2));
        end
    endtask

    initial begin
        send_idle = 32;
        recv_idle = 62;
        org = '{default: '0};
        inv_cell = 32'd65536;
        dim = '{default: 6'd32};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, grid extremes, edges and point extremes
        write_cell(0, 0, 0, '0, 1'b1);
        write_cell(31, 31, 31, '1, 1'b1);
        write_cell(31, 31, 31, '1, 1'b0);
        sample_point(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
        sample_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        sample_point(32'h001E_FFFF, 32'h001E_FFFF, 32'h001E_FFFF);
        sample_point(32'h001F_0000, 32'h0000_0000, 32'h0000_0000);
        sample_point(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000);
        sample_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        sample_point(32'h0001_0000, 32'h0002_0000, 32'h001F_0000);
        send_word(wtcs_pkg::OP_WRITE, {96'(0), 1'b1, 48'hFFFF_FFFF_FFFF, 15'h7FFF});
        random_words(60);

        configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 2, 2, 2);
        sample_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_words(140);

        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32, 32, 32);
        sample_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_words(100);

        configure(32'hFFFF_0000, 32'h0003_8000, 32'hFFF0_0000, 32'h0004_0000, 5, 17, 9);
        random_words(160);

        // pause until every outstanding result is back, then carry on
        drain();
        random_words(60);

        configure(32'h0, 32'h0, 32'h0, 32'd65536, 63, 0, 1);
        random_words(60);

        configure($urandom, $urandom, $urandom, 32'd0, 3, 3, 3);
        random_words(100);

        for (int p = 0; p < 4; p++) begin
            configure(32'($signed(32'($urandom_range(0, 400000))) - 200000),
                      32'($signed(32'($urandom_range(0, 400000))) - 200000),
                      32'($signed(32'($urandom_range(0, 400000))) - 200000),
                      32'($urandom_range(20000, 200000)),
                      $urandom_range(2, 32), $urandom_range(2, 32), $urandom_range(2, 32));
            random_words(130);
        end

        configure(32'h0, 32'h0, 32'h0, 32'd65536, 32, 32, 32);
        random_words(80);

        drain();
        $display("covered %0d words (%0d samples) over %0d register settings",
                 words_sent, samples_sent, settings_run);
        if (fail_count == 0)
            $display("weighted_trilinear_color_sampler_top_test: PASS");
        else
            $display("weighted_trilinear_color_sampler_top_test: FAIL");
        $finish;
    end

endmodule
